// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Holds the capacity, field widths, request and status codes and the cell link types.
// No dependencies.
package spq_pkg;

   // Queue depth and the widths that follow from it
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int FILL_W   = 5;
   localparam int REQ_TDATA_W = 2 * DATA_W;
   localparam int RSP_TDATA_W = ((2 * DATA_W + FILL_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * DATA_W - FILL_W;

   // Request kinds carried in req_tuser
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   // Result status carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic              insert_en;
      logic              remove_en;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] prio;
   } cell_cmd_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic              valid;
      logic              le;     // valid and own priority <= incoming priority
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] prio;
   } cell_link_type;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: valid bit, data and priority.
// Shifts toward the tail on insert, toward the head on remove.
// Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  cell_link_type left_in,
   input  cell_link_type right_in,
   output cell_link_type link_out
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] prio_ff, prio_in;
   logic              le;

   // Compare own priority against the incoming one (signed)
   assign le = valid_ff & ($signed(prio_ff) <= $signed(cmd.prio));

   // Pick next contents: keep, take the new entry, or take a neighbor
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (cmd.insert_en) begin
         if (!le) begin
            if (left_in.le) begin
               valid_in = 1'b1;
               data_in  = cmd.data;
               prio_in  = cmd.prio;
            end else begin
               valid_in = left_in.valid;
               data_in  = left_in.data;
               prio_in  = left_in.prio;
            end
         end
      end else if (cmd.remove_en) begin
         valid_in = right_in.valid;
         data_in  = right_in.data;
         prio_in  = right_in.prio;
      end
   end

   // Clear the valid bit on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign link_out.valid = valid_ff;
   assign link_out.le    = le;
   assign link_out.data  = data_ff;
   assign link_out.prio  = prio_ff;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: request decode, cell chain, result register.
// Depends on spq_pkg and spq_cell.
//
//  channel | dir | beat contents
//  req_    | in  | tuser: req_type; tdata: item_data, item_priority
//  rsp_    | out | tuser: status; tdata: out_data, out_priority, fill_count
//
// One request per cycle unless a result waits; every slot compares against the new priority in the
// same cycle, so the cell chain's compare and shift set the one-cycle rate.
// A result appears in the cycle after its request is taken.
// Reset clears the slot valid bits and the count at once; no clearing pass.
// While a result waits on rsp_tready low, req_tready is low too.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] item_data, [63:32] item_priority
   input  logic [0:0]             req_tuser,   // [0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] out_data, [63:32] out_priority,
                                               // [68:64] fill_count, rest zero
   output logic [1:0]             rsp_tuser    // [1:0] status
);

   logic                 accept;
   logic                 is_remove;
   logic                 full;
   logic                 empty;
   cell_cmd_type         cmd;
   cell_link_type        links [CAPACITY];
   cell_link_type        head_link;
   cell_link_type        tail_link;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [DATA_W-1:0]    odata_ff, odata_in;
   logic [DATA_W-1:0]    oprio_ff, oprio_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;

   // Decode the request beat
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_remove  = (req_tuser[0] == REQ_REMOVE);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   assign cmd.insert_en = accept && !is_remove && !full;
   assign cmd.remove_en = accept && is_remove && !empty;
   assign cmd.data      = req_tdata[DATA_W-1:0];
   assign cmd.prio      = req_tdata[2*DATA_W-1:DATA_W];

   // Chain ends: the head always takes a new entry, the tail feeds empty slots
   assign head_link = '{valid: 1'b1, le: 1'b1, data: '0, prio: '0};
   assign tail_link = '{valid: 1'b0, le: 1'b0, data: '0, prio: '0};

   // Build the chain of slots
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      if (i == 0) begin : g_head
         assign left_link = head_link;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_link = tail_link;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end
      spq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .left_in  (left_link),
         .right_in (right_link),
         .link_out (links[i])
      );
   end

   // Advance the count and form the result
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      odata_in  = odata_ff;
      oprio_in  = oprio_ff;
      fill_in   = fill_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         odata_in = '0;
         oprio_in = '0;
         if (is_remove) begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_REMOVED;
               odata_in  = links[0].data;
               oprio_in  = links[0].prio;
            end
         end else begin
            status_in = full ? ST_DROPPED : ST_INSERTED;
         end
         fill_in = FILL_W'(count_in);
      end
   end

   // Hold the result until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      odata_ff  <= odata_in;
      oprio_ff  <= oprio_in;
      fill_ff   <= fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, fill_ff, oprio_ff, odata_ff};

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core.
module spq_checker
   import spq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [1:0]             rsp_tuser
);

   // Stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // No request beat is taken while a result beat is stalled
   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request beat taken while result stalled");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Only a remove carries data; other beats are zero
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_REMOVED |-> rsp_tdata[2*DATA_W-1:0] == '0)
      else $error("nonzero data on a beat without a removal");

   // Empty and full reports agree with the count
   a_count_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != ST_EMPTY ||
                      rsp_tdata[2*DATA_W+FILL_W-1:2*DATA_W] == '0) &&
                     (rsp_tuser != ST_DROPPED ||
                      rsp_tdata[2*DATA_W+FILL_W-1:2*DATA_W] == FILL_W'(CAPACITY)))
      else $error("count disagrees with empty or full status");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/sorted_priority_queue_core_tb.sv =====
// Self-checking testbench for sorted_priority_queue_core: random and directed insert/remove beats.
// A class-based priority-order predictor checks every result beat field by field.
// Depends on spq_pkg and the RTL of sorted_priority_queue_core.
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_BEATS = 1700;
   localparam int DRAIN_CYCLES = 8;

   // Directed fill: extremes, ties at both ends and in the middle
   localparam logic [DATA_W-1:0] FILL_PRIO [16] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
      32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0001,
      32'hffff_fffb, 32'h0000_0005, 32'h7fff_ffff, 32'h8000_0000,
      32'h0000_0003, 32'hffff_ffff, 32'h0000_0002, 32'h0000_0007
   };

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] prio;
      logic [FILL_W-1:0] fill;
   } response_beat_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_RANDOM,
      RX_PERIODIC,
      RX_LONG
   } stall_mode_type;

   // Tracks the sorted queue contents and the results still owed by the block
   class response_predictor;
      logic signed [DATA_W-1:0] slot_data [CAPACITY];
      logic signed [DATA_W-1:0] slot_prio [CAPACITY];
      int                       entry_count;
      response_beat_type        pending_responses [$];
      int                       mismatches;
      int                       beats_seen;

      function new();
         entry_count = 0;
         mismatches  = 0;
         beats_seen  = 0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endtask

      // Apply one accepted request to the shadow queue and owe its result
      function void predict_request(req_kind_type kind, logic [DATA_W-1:0] d,
                                    logic [DATA_W-1:0] p);
         response_beat_type r;
         int                pos;
         int                i;
         r.status = ST_INSERTED;
         r.data   = '0;
         r.prio   = '0;
         if (kind == REQ_INSERT) begin
            if (entry_count >= CAPACITY) begin
               r.status = ST_DROPPED;
            end else begin
               // land after every entry with priority <= new one
               pos = 0;
               while (pos < entry_count && slot_prio[pos] <= $signed(p)) pos++;
               for (i = entry_count; i > pos; i--) begin
                  slot_data[i] = slot_data[i-1];
                  slot_prio[i] = slot_prio[i-1];
               end
               slot_data[pos] = d;
               slot_prio[pos] = p;
               entry_count++;
            end
         end else if (entry_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_REMOVED;
            r.data   = slot_data[0];
            r.prio   = slot_prio[0];
            for (i = 1; i < entry_count; i++) begin
               slot_data[i-1] = slot_data[i];
               slot_prio[i-1] = slot_prio[i];
            end
            entry_count--;
         end
         r.fill = FILL_W'(entry_count);
         pending_responses.push_back(r);
      endfunction

      // Compare one result beat against the oldest owed result
      task check_response(logic [1:0] st, logic [DATA_W-1:0] d, logic [DATA_W-1:0] p,
                          logic [FILL_W-1:0] fill);
         response_beat_type e;
         beats_seen++;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("beat %0d: result with nothing outstanding", beats_seen));
         end else begin
            e = pending_responses.pop_front();
            if (st !== e.status)
               report_mismatch($sformatf("beat %0d: status %0d, want %0d",
                                         beats_seen, st, e.status));
            if (d !== e.data)
               report_mismatch($sformatf("beat %0d: out_data %h, want %h",
                                         beats_seen, d, e.data));
            if (p !== e.prio)
               report_mismatch($sformatf("beat %0d: out_priority %h, want %h",
                                         beats_seen, p, e.prio));
            if (fill !== e.fill)
               report_mismatch($sformatf("beat %0d: fill_count %0d, want %0d",
                                         beats_seen, fill, e.fill));
         end
      endtask

      function int outstanding();
         return pending_responses.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   response_predictor queue_model = new();
   int                cycle_count = 0;
   int                burst_left = 0;
   stall_mode_type    stall_mode = RX_STEADY;
   int                stall_span = 0;
   int                stall_hold = 0;
   int                stall_phase = 0;

   sorted_priority_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #CLK_HALF clock = ~clock;

   // Count cycles, watch for a hang, check every accepted result beat
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_priority_queue_core_tb: FAIL");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         queue_model.check_response(rsp_tuser, rsp_tdata[DATA_W-1:0],
                                    rsp_tdata[2*DATA_W-1:DATA_W],
                                    rsp_tdata[2*DATA_W +: FILL_W]);
      end
   end

   // Receiver back-pressure: switch between randomly chosen stall patterns at random intervals
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(10, 80);
      end
      stall_span--;
      stall_phase++;
      case (stall_mode)
         RX_STEADY:   rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_tready <= (stall_phase % 3 != 0);
         default: begin
            if (stall_hold == 0) begin
               rsp_tready <= ~rsp_tready;
               stall_hold = $urandom_range(1, 12);
            end else begin
               stall_hold--;
            end
         end
      endcase
   end

   // Present one request beat and hold it until the block takes it
   task send_request(req_kind_type kind, logic [DATA_W-1:0] d, logic [DATA_W-1:0] p);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {p, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queue_model.predict_request(kind, d, p);
      // end of burst: drop valid for a random gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Hold off the sender until every owed result has come back
   task wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (queue_model.outstanding() != 0) @(posedge clock);
   endtask

   // Half the picks from a narrow band around zero for ties, plus full range and extremes
   function automatic logic [DATA_W-1:0] pick_priority();
      logic [DATA_W-1:0] edge_val;
      edge_val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return DATA_W'($urandom_range(0, 7)) - 4;
         5, 6, 7:       return $urandom;
         8:             return edge_val;
         default:       return edge_val ^ DATA_W'($urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int n;
      int phase_left;
      int insert_pct;
      req_kind_type kind;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: remove from empty, fill with extremes and ties, overfill, pop a few
      send_request(REQ_REMOVE, $urandom, $urandom);
      for (n = 0; n < 16; n++) begin
         case (n)
            0:       send_request(REQ_INSERT, 32'h8000_0000, FILL_PRIO[n]);
            1:       send_request(REQ_INSERT, 32'h7fff_ffff, FILL_PRIO[n]);
            2:       send_request(REQ_INSERT, 32'h0000_0000, FILL_PRIO[n]);
            3:       send_request(REQ_INSERT, 32'hffff_ffff, FILL_PRIO[n]);
            default: send_request(REQ_INSERT, 32'h100 + n, FILL_PRIO[n]);
         endcase
      end
      send_request(REQ_INSERT, 32'hdead_beef, 32'h8000_0000);
      repeat (5) send_request(REQ_REMOVE, $urandom, $urandom);
      wait_for_drain();

      // Random: phases that lean toward filling, draining, or hovering
      phase_left = 0;
      insert_pct = 50;
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 3))
               0:       insert_pct = 85;
               1:       insert_pct = 15;
               2:       insert_pct = 50;
               default: insert_pct = 95;
            endcase
            phase_left = $urandom_range(20, 120);
         end
         phase_left--;
         if (n == RANDOM_BEATS / 2) wait_for_drain();
         kind = ($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT : REQ_REMOVE;
         send_request(kind, $urandom, (kind == REQ_INSERT) ? pick_priority() : $urandom);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (queue_model.mismatches == 0) begin
         $display("sorted_priority_queue_core_tb: PASS");
      end else begin
         $display("sorted_priority_queue_core_tb: FAIL");
      end
      $finish;
   end

endmodule
